[hw/rtl/rar_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rar_pkg: shared constants and types for the rational arithmetic block
// Operation codes, default operand width and the result numerator and denominator widths.
// ----------------------------------------------------------------------------
package rar_pkg;

  localparam int OPERAND_WIDTH_DEF = 16;
  localparam int KIND_W = 3;
  localparam int NUM_W = 33;
  localparam int DEN_W = 32;

  localparam logic [KIND_W-1:0] KIND_ADD = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SUB = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MUL = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DIV = 3'd3;
  // Reduce the first fraction; the unused codes above it behave the same.
  localparam logic [KIND_W-1:0] KIND_RED = 3'd4;

  // Control from the sequencer to the divide unit.
  typedef struct packed {
    logic start;
  } div_ctl_t;

endpackage
`default_nettype wire

[hw/rtl/rar_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rar_div: restoring unsigned divider
// Produces quotient and remainder of two magnitudes, one bit per cycle.
// ----------------------------------------------------------------------------
module rar_div #(
  parameter int W = 64
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire rar_pkg::div_ctl_t ctl,
  input  wire logic [W-1:0]  dividend,
  input  wire logic [W-1:0]  divisor,
  output logic               done,
  output logic [W-1:0]       quo,
  output logic [W-1:0]       rem
);
  import rar_pkg::*;

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  q_r, q_nxt;
  logic [W-1:0]  r_r, r_nxt;
  logic [W-1:0]  d_r, d_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    trial;
  logic [W:0]    diff;

  // One shift-subtract step of the restoring division.
  always_comb begin
    q_nxt = q_r;
    r_nxt = r_r;
    d_nxt = d_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {r_r, q_r[W-1]};
    diff = trial - {1'b0, d_r};
    if (ctl.start) begin
      q_nxt = dividend;
      r_nxt = '0;
      d_nxt = divisor;
      cnt_nxt = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[W]) begin
        r_nxt = diff[W-1:0];
        q_nxt = {q_r[W-2:0], 1'b1};
      end else begin
        r_nxt = trial[W-1:0];
        q_nxt = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
  end

  assign done = done_r;
  assign quo = q_r;
  assign rem = r_r;

endmodule
`default_nettype wire

[hw/rtl/rational_arith_reduce_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rational_arith_reduce_top: rational arithmetic with gcd reduction
// Adds, subtracts, multiplies or divides two fractions, or reduces one, and
// divides the result by the Euclid greatest common divisor.
// ----------------------------------------------------------------------------
// One word is taken at a time; in_tready stays low until its result word has
// been taken. Work runs through one shared restoring divider that retires
// 2*OPERAND_WIDTH+1 quotient bits per division. An item passes through the
// products and sign split (S_MUL1, S_MUL2, S_SPLIT), one division per Euclid
// step (up to about 48 steps on the worst operands, usually far fewer), a
// check that sees the loop end, two final divisions and the result state
// S_OUT, where it waits until the result word is taken with out_tready high.
// 0/0 returns 0/0 with err set and skips the divisions; x/0 reduces to 1/0.
module rational_arith_reduce_top #(
  parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // a_num, a_den, b_num, b_den from the lowest bit up
  input  wire logic [((4*OPERAND_WIDTH+7)/8)*8-1:0] in_tdata,
  // kind
  input  wire logic [rar_pkg::KIND_W-1:0]    in_tuser,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // res_num, res_den from the lowest bit up, zero padded
  output logic [71:0]                        out_tdata,
  // err
  output logic                               out_tuser
);
  import rar_pkg::*;

  localparam int OW = OPERAND_WIDTH;
  localparam int PW = 2 * OW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL1, S_MUL2, S_SPLIT, S_EUCLID, S_EWAIT,
    S_QNUM, S_QNWAIT, S_QDEN, S_QDWAIT, S_OUT
  } state_t;

  state_t         state_r;
  logic [KIND_W-1:0] kind_r;
  logic signed [OW-1:0] an_r, ad_r, bn_r, bd_r;
  logic signed [2*OW-1:0] p1_r;
  logic signed [PW-1:0] num_r, den_r;
  logic           nneg_r, dneg_r, idx_r;
  logic [PW-1:0]  nmag_r, dmag_r, x_r, y_r;
  logic [NUM_W-1:0] res_num_r;
  logic [DEN_W-1:0] res_den_r;
  logic           err_r;

  // Shared multiplier operands; one product a cycle.
  logic signed [OW-1:0] ma, mb;
  logic signed [2*OW-1:0] prod;

  div_ctl_t       dctl;
  logic           ddone;
  logic [PW-1:0]  dquo, drem, ddend, dsor;

  logic [PW-1:0]  q_signed;
  logic           gneg;
  logic signed [PW-1:0] num_f;

  always_comb begin
    ma = an_r;
    mb = bd_r;
    unique case (state_r)
      S_MUL1: begin
        unique case (kind_r)
          KIND_MUL: begin ma = an_r; mb = bn_r; end
          default: begin ma = an_r; mb = bd_r; end
        endcase
      end
      S_MUL2: begin
        unique case (kind_r)
          KIND_DIV: begin ma = ad_r; mb = bn_r; end
          default: begin ma = ad_r; mb = bd_r; end
        endcase
      end
      default: begin ma = ad_r; mb = bn_r; end
    endcase
    prod = ma * mb;
  end

  assign gneg = idx_r ? dneg_r : nneg_r;
  assign dctl.start = (state_r == S_EUCLID) || (state_r == S_QNUM) ||
                      (state_r == S_QDEN);
  assign ddend = (state_r == S_QNUM) ? nmag_r :
                 (state_r == S_QDEN) ? dmag_r : x_r;
  assign dsor = (state_r == S_EUCLID) ? y_r : x_r;

  rar_div #(.W(PW)) u_div (
    .clk(clk), .rst_n(rst_n), .ctl(dctl), .dividend(ddend), .divisor(dsor),
    .done(ddone), .quo(dquo), .rem(drem)
  );

  // Quotient with the sign fixed by the divisor's sign rule.
  always_comb begin
    q_signed = dquo;
    if ((state_r == S_QNWAIT) && (nneg_r != gneg)) q_signed = PW'(0) - dquo;
    if ((state_r == S_QDWAIT) && (dneg_r != gneg)) q_signed = PW'(0) - dquo;
  end

  // Finished numerator; the third product ad*bn is on the multiplier now.
  always_comb begin
    num_f = num_r;
    case (kind_r)
      KIND_ADD: num_f = PW'(p1_r) + PW'(prod);
      KIND_SUB: num_f = PW'(p1_r) - PW'(prod);
      KIND_MUL, KIND_DIV: num_f = PW'(p1_r);
      default: num_f = num_r;
    endcase
  end

  // Sequencer: products, Euclid loop, two final divisions.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_tvalid) begin
          state_r <= S_MUL1;
          an_r <= in_tdata[OW-1:0];
          ad_r <= in_tdata[2*OW-1:OW];
          bn_r <= in_tdata[3*OW-1:2*OW];
          bd_r <= in_tdata[4*OW-1:3*OW];
          kind_r <= in_tuser;
        end
        S_MUL1: begin p1_r <= prod; state_r <= S_MUL2; end
        S_MUL2: begin
          state_r <= S_SPLIT;
          unique case (kind_r) inside
            KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV: begin
              den_r <= PW'(prod);
            end
            default: begin
              num_r <= PW'(an_r);
              den_r <= PW'(ad_r);
            end
          endcase
        end
        default: ;
      endcase
      // Sign split of the unreduced pair, loaded as the loop enters.
      if (state_r == S_SPLIT) begin
        nneg_r <= num_f[PW-1];
        dneg_r <= den_r[PW-1];
        nmag_r <= num_f[PW-1] ? PW'(0) - num_f : num_f;
        dmag_r <= den_r[PW-1] ? PW'(0) - den_r : den_r;
        x_r <= num_f[PW-1] ? PW'(0) - num_f : num_f;
        y_r <= den_r[PW-1] ? PW'(0) - den_r : den_r;
        idx_r <= 1'b0;
        state_r <= S_EUCLID;
      end
      unique case (state_r)
        S_EUCLID: begin
          if (y_r == '0) begin
            state_r <= (x_r == '0) ? S_OUT : S_QNUM;
            if (x_r == '0) begin
              err_r <= 1'b1;
              res_num_r <= '0;
              res_den_r <= '0;
            end
          end else begin
            state_r <= S_EWAIT;
          end
        end
        S_EWAIT: if (ddone) begin
          x_r <= y_r;
          y_r <= drem;
          idx_r <= ~idx_r;
          state_r <= S_EUCLID;
        end
        S_QNUM: state_r <= S_QNWAIT;
        S_QNWAIT: if (ddone) begin
          res_num_r <= NUM_W'($signed(q_signed));
          state_r <= S_QDEN;
        end
        S_QDEN: state_r <= S_QDWAIT;
        S_QDWAIT: if (ddone) begin
          res_den_r <= DEN_W'($signed(q_signed));
          err_r <= 1'b0;
          state_r <= S_OUT;
        end
        S_OUT: if (out_tready) state_r <= S_IDLE;
        default: ;
      endcase
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata = {7'd0, res_den_r, res_num_r};
  assign out_tuser = err_r;

`ifndef SYNTHESIS
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("ready while result pending");
  a_err0: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == '0)) else $error("err not 0/0");
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready) else $error("accepted twice");
`endif

endmodule
`default_nettype wire
